[sv/gwf_pkg.sv]
// gwf_pkg: shared types and constants of the grid wall face mesher
// used by gwf_ctrl, gwf_datapath and grid_wall_face_mesher
package gwf_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BEGIN = 2'd1,
    ACT_MESH  = 2'd2
  } action_e;

  localparam logic [0:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [0:0] REG_GRID_HEIGHT = 1'd1;

  // face codes, equal to the normal code for real faces
  localparam logic [2:0] FACE_TOP   = 3'd0;
  localparam logic [2:0] FACE_SOUTH = 3'd1;
  localparam logic [2:0] FACE_NORTH = 3'd2;
  localparam logic [2:0] FACE_EAST  = 3'd3;
  localparam logic [2:0] FACE_WEST  = 3'd4;
  localparam logic [2:0] FACE_FLOOR = 3'd5;

  localparam int NumFaces = 6;
  localparam int NumProbes = 5;

  typedef logic [NumFaces-1:0] face_mask_t;

  typedef struct packed {
    logic       latch;   // capture the cell coordinates of the accepted word
    logic       load;    // write the wall flag
    logic       begin_mesh;
    logic       rd_en;   // read one probe cell into the neighbour flags
    logic [2:0] probe;
    logic       build;   // form the face mask from the flags
    logic       step;    // emit one vertex into the output register
  } gwf_cmd_t;

  typedef struct packed {
    logic in_grid;
    logic center_wall;
    logic last_vtx;
    logic out_free;
  } gwf_status_t;

  // corner offsets {dx, up, dz} of the mesh faces
  function automatic logic [2:0] face_corner(input logic [2:0] face, input logic [1:0] c);
    logic [2:0] r;
    r = 3'b000;
    case (face)
      FACE_TOP: begin
        case (c)
          2'd0:    r = 3'b010;
          2'd1:    r = 3'b011;
          2'd2:    r = 3'b110;
          default: r = 3'b111;
        endcase
      end
      FACE_SOUTH: begin
        case (c)
          2'd0:    r = 3'b100;
          2'd1:    r = 3'b000;
          2'd2:    r = 3'b110;
          default: r = 3'b010;
        endcase
      end
      FACE_NORTH: begin
        case (c)
          2'd0:    r = 3'b101;
          2'd1:    r = 3'b001;
          2'd2:    r = 3'b111;
          default: r = 3'b011;
        endcase
      end
      FACE_EAST: begin
        case (c)
          2'd0:    r = 3'b100;
          2'd1:    r = 3'b101;
          2'd2:    r = 3'b110;
          default: r = 3'b111;
        endcase
      end
      FACE_WEST: begin
        case (c)
          2'd0:    r = 3'b000;
          2'd1:    r = 3'b001;
          2'd2:    r = 3'b010;
          default: r = 3'b011;
        endcase
      end
      default: r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

[sv/gwf_ctrl.sv]
// gwf_ctrl: sequencer of the grid wall face mesher
// depends on gwf_pkg; drives gwf_datapath through gwf_cmd_t
module gwf_ctrl import gwf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  gwf_status_t st_i,
  output gwf_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_EMIT
  } state_e;

  state_e     state_q;
  logic [2:0] probe_q;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    cmd_o            = '0;
    cmd_o.latch      = accept;
    cmd_o.load       = accept && (action_e'(action_i) == ACT_LOAD);
    cmd_o.begin_mesh = accept && (action_e'(action_i) == ACT_BEGIN);
    cmd_o.rd_en      = (state_q == S_READ);
    cmd_o.probe      = probe_q;
    cmd_o.build      = (state_q == S_CHECK) && st_i.center_wall;
    cmd_o.step       = (state_q == S_EMIT) && st_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      probe_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          probe_q <= '0;
          if (accept) begin
            case (action_e'(action_i))
              ACT_BEGIN: state_q <= S_EMIT;
              ACT_MESH:  state_q <= st_i.in_grid ? S_READ : S_IDLE;
              default:   state_q <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          probe_q <= probe_q + 3'd1;
          if (probe_q == 3'(NumProbes - 1)) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          // an open cell yields nothing
          state_q <= st_i.center_wall ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (st_i.out_free && st_i.last_vtx) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/gwf_datapath.sv]
// gwf_datapath: wall map memory, grid size registers, vertex generator
// and output register; depends on gwf_pkg, commanded by gwf_ctrl
module gwf_datapath import gwf_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  gwf_cmd_t    cmd_i,
  output gwf_status_t st_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic        is_wall_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  pos_x_o,
  output logic        pos_up_o,
  output logic [6:0]  pos_z_o,
  output logic [2:0]  normal_code_o,
  output logic        tex_u_o,
  output logic        tex_v_o,
  output logic [16:0] vertex_number_o,
  output logic        reversed_winding_o,
  output logic        last_o
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);

  logic [6:0]  grid_w_q, grid_h_q;
  logic [6:0]  w_eff, h_eff;
  logic [5:0]  cx_q, cy_q;
  logic        wall_mem_q [Depth];
  logic [NumProbes-1:0] wall_q;
  face_mask_t  mask_q, mask_rest;
  logic [1:0]  corner_q;
  logic [16:0] cnt_q;
  logic [2:0]  face;
  logic [2:0]  offs;
  logic        last_d;
  logic [6:0]  nx, ny;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        wr_ok;
  logic        out_valid_q;

  // a size of zero counts as one, a size above the store counts as its maximum
  always_comb begin
    if (grid_w_q == 7'd0) w_eff = 7'd1;
    else if (32'(grid_w_q) > MAX_WIDTH) w_eff = 7'(MAX_WIDTH);
    else w_eff = grid_w_q;
    if (grid_h_q == 7'd0) h_eff = 7'd1;
    else if (32'(grid_h_q) > MAX_HEIGHT) h_eff = 7'(MAX_HEIGHT);
    else h_eff = grid_h_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= 7'd64;
      grid_h_q <= 7'd64;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_GRID_WIDTH) grid_w_q <= cfg_data_i;
      if (cfg_index_i == REG_GRID_HEIGHT) grid_h_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cx_q <= cell_x_i;
      cy_q <= cell_y_i;
    end
  end

  // probe order: center, south, north, east, west
  always_comb begin
    nx = {1'b0, cx_q};
    ny = {1'b0, cy_q};
    case (cmd_i.probe)
      3'd1:    ny = {1'b0, cy_q} - 7'd1;
      3'd2:    ny = {1'b0, cy_q} + 7'd1;
      3'd3:    nx = {1'b0, cx_q} + 7'd1;
      3'd4:    nx = {1'b0, cx_q} - 7'd1;
      default: ;
    endcase
  end

  assign rd_addr = AW'(32'(ny) * MAX_WIDTH + 32'(nx));
  assign wr_addr = AW'(32'(cell_y_i) * MAX_WIDTH + 32'(cell_x_i));
  assign wr_ok   = (32'(cell_x_i) < MAX_WIDTH) && (32'(cell_y_i) < MAX_HEIGHT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_ok) begin
      wall_mem_q[wr_addr] <= is_wall_i;
    end
    if (cmd_i.rd_en) begin
      wall_q[cmd_i.probe] <= wall_mem_q[rd_addr];
    end
  end

  // current face is the lowest pending one
  always_comb begin
    face = FACE_TOP;
    for (int i = NumFaces - 1; i >= 0; i--) begin
      if (mask_q[i]) face = 3'(i);
    end
  end

  always_comb begin
    mask_rest       = mask_q;
    mask_rest[face] = 1'b0;
  end

  assign last_d = (corner_q == 2'd3) && (mask_rest == '0);
  assign offs   = face_corner(face, corner_q);

  assign st_o.in_grid     = ({1'b0, cell_x_i} < w_eff) && ({1'b0, cell_y_i} < h_eff);
  assign st_o.center_wall = wall_q[0];
  assign st_o.last_vtx    = last_d;
  assign st_o.out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      corner_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (cmd_i.begin_mesh) begin
        mask_q          <= face_mask_t'(1'b1) << FACE_FLOOR;
        corner_q        <= '0;
        cnt_q           <= '0;
      end else if (cmd_i.build) begin
        corner_q <= '0;
        mask_q   <= {1'b0,
                     (cx_q != 6'd0) && !wall_q[4],
                     ({1'b0, cx_q} + 7'd1 < w_eff) && !wall_q[3],
                     ({1'b0, cy_q} + 7'd1 < h_eff) && !wall_q[2],
                     (cy_q != 6'd0) && !wall_q[1],
                     1'b1};
      end else if (cmd_i.step) begin
        corner_q <= corner_q + 2'd1;
        cnt_q    <= cnt_q + 17'd1;
        if (corner_q == 2'd3) mask_q <= mask_rest;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      if (face == FACE_FLOOR) begin
        pos_x_o            <= corner_q[1] ? w_eff : 7'd0;
        pos_up_o           <= 1'b0;
        pos_z_o            <= corner_q[0] ? h_eff : 7'd0;
        normal_code_o      <= FACE_TOP;
        reversed_winding_o <= 1'b0;
      end else begin
        pos_x_o            <= {1'b0, cx_q} + {6'd0, offs[2]};
        pos_up_o           <= offs[1];
        pos_z_o            <= {1'b0, cy_q} + {6'd0, offs[0]};
        normal_code_o      <= face;
        reversed_winding_o <= (face == FACE_NORTH) || (face == FACE_EAST);
      end
      tex_u_o         <= corner_q[1];
      tex_v_o         <= corner_q[0];
      vertex_number_o <= cnt_q;
      last_o          <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_step_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (!out_valid_q || !out_stall_i))
    else $error("vertex emitted into an occupied output register");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !cmd_i.begin_mesh && !cmd_i.build) |=> (cnt_q == $past(cnt_q) + 17'd1))
    else $error("vertex counter did not advance by one");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && last_d) |=> (mask_q == '0))
    else $error("faces still pending after the last vertex");

  a_step_has_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (mask_q != '0))
    else $error("vertex emitted with no face pending");
`endif

endmodule

[sv/grid_wall_face_mesher.sv]
// grid_wall_face_mesher: a load leaves the controller idle; begin emits 4 floor vertices
// a mesh word is accepted, then makes 5 wall map reads (one memory read port) and a check,
// then emits one vertex per cycle (4 to 20 vertices) while the output flows
// the last vertex waits in the output register while the next word is taken
// reset clears the controller, vertex counter and grid sizes (64 x 64); the wall map is not cleared
module grid_wall_face_mesher import gwf_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic        is_wall_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  pos_x_o,
  output logic        pos_up_o,
  output logic [6:0]  pos_z_o,
  output logic [2:0]  normal_code_o,
  output logic        tex_u_o,
  output logic        tex_v_o,
  output logic [16:0] vertex_number_o,
  output logic        reversed_winding_o,
  output logic        last_o
);

  gwf_cmd_t    cmd;
  gwf_status_t st;

  gwf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  gwf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .st_o               (st),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .cell_x_i           (cell_x_i),
    .cell_y_i           (cell_y_i),
    .is_wall_i          (is_wall_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pos_x_o            (pos_x_o),
    .pos_up_o           (pos_up_o),
    .pos_z_o            (pos_z_o),
    .normal_code_o      (normal_code_o),
    .tex_u_o            (tex_u_o),
    .tex_v_o            (tex_v_o),
    .vertex_number_o    (vertex_number_o),
    .reversed_winding_o (reversed_winding_o),
    .last_o             (last_o)
  );

endmodule
